### hw/rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types, constants and helpers for the escape-time grid point tester.
// ----------------------------------------------------------------------------
package mbt_pkg;

    // grid and fixed-point format
    localparam int GRID_MAX   = 1024;
    localparam int IDX_W      = 10;
    localparam int Q_W        = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int FRAC_BITS  = 28;
    localparam int WIDE_W     = 48;
    localparam int PROD_W     = 64;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    // escape radius 2, squared, in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_SQ = 64'h0400_0000_0000_0000;

    // register reset values
    localparam logic signed [Q_W-1:0] X_LEFT_RST   = 32'shE000_0000;
    localparam logic signed [Q_W-1:0] Y_BOTTOM_RST = 32'shF000_0000;
    localparam logic [STEP_W-1:0]     STEP_RST     = 31'h0199_999A;
    localparam logic [ITER_W-1:0]     MAX_ITER_RST = 16'd256;

    // register map, word index
    typedef enum logic [1:0] {
        REG_X_LEFT    = 2'd0,
        REG_Y_BOTTOM  = 2'd1,
        REG_STEP      = 2'd2,
        REG_MAX_ITERS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0] col_index;
        logic [IDX_W-1:0] row_index;
    } in_item_t;

    typedef struct packed {
        logic              in_set;
        logic [ITER_W-1:0] iter_count;
    } out_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] x_left;
        logic signed [Q_W-1:0] y_bottom;
        logic [STEP_W-1:0]     step;
        logic [ITER_W-1:0]     max_iters;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
    } point_t;

    // saturate a wide signed value to the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        begin
            hi = {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
            lo = {{(WIDE_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
            if (v > hi)
                sat_q = hi[Q_W-1:0];
            else if (v < lo)
                sat_q = lo[Q_W-1:0];
            else
                sat_q = v[Q_W-1:0];
        end
    endfunction

    // clamp an index to the last grid tick
    function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        begin
            wide = {{(32-IDX_W){1'b0}}, idx};
            if (wide >= 32'(GRID_MAX))
                clamp_index = IDX_W'(GRID_MAX - 1);
            else
                clamp_index = idx;
        end
    endfunction

endpackage

### hw/rtl/mbt_cfg.sv
// ----------------------------------------------------------------------------
// mbt_cfg
// APB register file for the grid origin, tick spacing and iteration limit.
// ----------------------------------------------------------------------------
module mbt_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbt_pkg::ADDR_W-1:0] paddr,
    input  logic [mbt_pkg::DATA_W-1:0] pwdata,
    output logic [mbt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output mbt_pkg::cfg_t              cfg
);
    import mbt_pkg::*;

    logic signed [Q_W-1:0] x_left_reg;
    logic signed [Q_W-1:0] y_bottom_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [ITER_W-1:0]     max_iters_reg;
    reg_idx_t              idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_left_reg    <= X_LEFT_RST;
            y_bottom_reg  <= Y_BOTTOM_RST;
            step_reg      <= STEP_RST;
            max_iters_reg <= MAX_ITER_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_X_LEFT:    x_left_reg    <= pwdata;
                REG_Y_BOTTOM:  y_bottom_reg  <= pwdata;
                REG_STEP:      step_reg      <= pwdata[STEP_W-1:0];
                REG_MAX_ITERS: max_iters_reg <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_X_LEFT:    prdata = x_left_reg;
            REG_Y_BOTTOM:  prdata = y_bottom_reg;
            REG_STEP:      prdata = {{(DATA_W-STEP_W){1'b0}}, step_reg};
            REG_MAX_ITERS: prdata = {{(DATA_W-ITER_W){1'b0}}, max_iters_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.x_left    = x_left_reg;
    assign cfg.y_bottom  = y_bottom_reg;
    assign cfg.step      = step_reg;
    assign cfg.max_iters = max_iters_reg;

endmodule

### hw/rtl/mbt_front.sv
// ----------------------------------------------------------------------------
// mbt_front
// Turns grid indexes into a Q4.28 point and holds it in a short point queue.
// ----------------------------------------------------------------------------
module mbt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  mbt_pkg::cfg_t     cfg,
    input  logic              push,
    output logic              full,
    input  mbt_pkg::in_item_t item,
    output logic              pt_valid,
    output mbt_pkg::point_t   pt,
    input  logic              pt_take
);
    import mbt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MUL_W = IDX_W + STEP_W;

    point_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;
    logic [IDX_W-1:0]    col, row;
    logic [MUL_W-1:0]    col_off, row_off;
    logic signed [WIDE_W-1:0] re_sum, im_sum;
    point_t              new_pt;

    // point = origin + index * step, saturated
    always_comb
    begin
        col     = clamp_index(item.col_index);
        row     = clamp_index(item.row_index);
        col_off = MUL_W'(col) * MUL_W'(cfg.step);
        row_off = MUL_W'(row) * MUL_W'(cfg.step);
        re_sum  = WIDE_W'(cfg.x_left) + $signed({{(WIDE_W-MUL_W){1'b0}}, col_off});
        im_sum  = WIDE_W'(cfg.y_bottom) + $signed({{(WIDE_W-MUL_W){1'b0}}, row_off});
        new_pt.c_re = sat_q(re_sum);
        new_pt.c_im = sat_q(im_sum);
    end

    // queue control
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pt_valid = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pt_take && pt_valid;
    assign pt       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= new_pt;
    end

endmodule

### hw/rtl/mbt_back.sv
// ----------------------------------------------------------------------------
// mbt_back
// Iterates z = z*z + c on one point and holds the result until it is taken.
// ----------------------------------------------------------------------------
module mbt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mbt_pkg::cfg_t      cfg,
    input  logic               pt_valid,
    input  mbt_pkg::point_t    pt,
    output logic               pt_take,
    output logic               empty,
    input  logic               pop,
    output mbt_pkg::out_item_t result
);
    import mbt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic signed [Q_W-1:0]      re_reg, im_reg;
    logic signed [Q_W-1:0]      c_re_reg, c_im_reg;
    logic signed [PROD_W-1:0]   rr_reg, ii_reg, ri_reg;
    logic [ITER_W-1:0]          k_reg;
    logic                       in_set_reg;
    logic [ITER_W-1:0]          count_reg;

    logic signed [PROD_W:0]     diff;
    logic signed [PROD_W:0]     diff_sh;
    logic signed [PROD_W-1:0]   ri_sh;
    logic signed [WIDE_W-1:0]   re_sum, im_sum;
    logic signed [Q_W-1:0]      re_next, im_next;
    logic [PROD_W-1:0]          mag;
    logic                       escaped;

    assign pt_take = (state_reg == S_IDLE) && pt_valid;
    assign empty   = (state_reg != S_DONE);
    assign result.in_set     = in_set_reg;
    assign result.iter_count = count_reg;

    // update path and escape test
    always_comb
    begin
        diff    = $signed({rr_reg[PROD_W-1], rr_reg}) - $signed({ii_reg[PROD_W-1], ii_reg});
        diff_sh = diff >>> FRAC_BITS;
        ri_sh   = ri_reg >>> (FRAC_BITS - 1);
        re_sum  = diff_sh[WIDE_W-1:0] + WIDE_W'(c_re_reg);
        im_sum  = ri_sh[WIDE_W-1:0] + WIDE_W'(c_im_reg);
        re_next = sat_q(re_sum);
        im_next = sat_q(im_sum);
        mag     = rr_reg + ii_reg;
        escaped = (k_reg != '0) && (mag > ESCAPE_SQ);
    end

    // iteration sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            re_reg     <= '0;
            im_reg     <= '0;
            c_re_reg   <= '0;
            c_im_reg   <= '0;
            rr_reg     <= '0;
            ii_reg     <= '0;
            ri_reg     <= '0;
            k_reg      <= '0;
            in_set_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pt_valid)
                    begin
                        re_reg    <= pt.c_re;
                        im_reg    <= pt.c_im;
                        c_re_reg  <= pt.c_re;
                        c_im_reg  <= pt.c_im;
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    rr_reg    <= re_reg * re_reg;
                    ii_reg    <= im_reg * im_reg;
                    ri_reg    <= re_reg * im_reg;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    priority if (escaped)
                    begin
                        in_set_reg <= 1'b0;
                        count_reg  <= k_reg;
                        state_reg  <= S_DONE;
                    end
                    else if (k_reg == cfg.max_iters)
                    begin
                        in_set_reg <= 1'b1;
                        count_reg  <= k_reg;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        re_reg    <= re_next;
                        im_reg    <= im_next;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (pop)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // iteration count never passes the limit while a point is in work
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_UPD) |-> (k_reg <= cfg.max_iters))
        else $error("iteration count beyond limit");

    // a point in the set always reports the full limit
    a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && in_set_reg) |-> (count_reg == cfg.max_iters))
        else $error("in-set result with short count");

    // an escape is only reported after at least one update
    a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !in_set_reg) |-> (count_reg != '0))
        else $error("escape reported before any update");

    // a point is only taken when the engine is free, and it then starts an iteration
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pt_take |=> (state_reg == S_MUL))
        else $error("point taken without starting iteration");

endmodule

### hw/rtl/mandelbrot_grid_point_test_top.sv
// Each point goes from the queue into the iteration engine, whose three-multiplier
// stage and update stage take turns until the point escapes or the limit is hit;
// the engine takes no new point until the result of the last one is popped.
// A two-entry point queue takes pushes while the engine works or a result waits.
// Reset (rst_n low, asynchronous) empties both sides and restores register defaults.
// ----------------------------------------------------------------------------
// mandelbrot_grid_point_test_top
// Escape-time test of one grid point per transfer, with an APB register port.
// ----------------------------------------------------------------------------
module mandelbrot_grid_point_test_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbt_pkg::ADDR_W-1:0] paddr,
    input  logic [mbt_pkg::DATA_W-1:0] pwdata,
    output logic [mbt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       push,
    output logic                       full,
    input  mbt_pkg::in_item_t          item,
    output logic                       empty,
    input  logic                       pop,
    output mbt_pkg::out_item_t         result
);
    import mbt_pkg::*;

    cfg_t   cfg;
    point_t pt;
    logic   pt_valid;
    logic   pt_take;

    // configuration registers
    mbt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // point former and queue
    mbt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .full     (full),
        .item     (item),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_take  (pt_take)
    );

    // iteration engine and result register
    mbt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_take  (pt_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

### dv/escape_time_checker.sv
// ----------------------------------------------------------------------------
// escape_time_checker
// Watches the register port and both queue sides of the grid point tester.
// Keeps its own copy of the view settings, computes the escape result of each
// point at its input transfer, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module escape_time_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [mbt_pkg::ADDR_W-1:0] paddr,
    input  logic [mbt_pkg::DATA_W-1:0] pwdata,
    input  logic                       push,
    input  logic                       full,
    input  mbt_pkg::in_item_t          item,
    input  logic                       empty,
    input  logic                       pop,
    input  mbt_pkg::out_item_t         result,
    output int                         mismatches,
    output int                         in_flight
);
    import mbt_pkg::*;

    localparam logic signed [63:0] Q_HI = 64'sd2147483647;
    localparam logic signed [63:0] Q_LO = -64'sd2147483648;

    // view settings as the block should hold them
    logic signed [Q_W-1:0] x_left    = X_LEFT_RST;
    logic signed [Q_W-1:0] y_bottom  = Y_BOTTOM_RST;
    logic [STEP_W-1:0]     step      = STEP_RST;
    logic [ITER_W-1:0]     max_iters = MAX_ITER_RST;

    // escape results of accepted points, oldest first
    out_item_t predicted_escapes[$];

    // clip a wide value into the Q4.28 range
    function automatic logic signed [63:0] clip_q(input logic signed [63:0] v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    // iterate z = z*z + c from z = c and report escape and count
    function automatic out_item_t escape_time(input in_item_t pt);
        logic signed [63:0] xl;
        logic signed [63:0] yb;
        logic signed [63:0] col_off;
        logic signed [63:0] row_off;
        logic signed [63:0] c_re;
        logic signed [63:0] c_im;
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic signed [63:0] rr;
        logic signed [63:0] ii;
        logic signed [63:0] ri;
        logic [63:0]        mag;
        int unsigned        k;
        bit                 escaped;
        out_item_t          r;
        // indices are 10 bits wide, so they never pass the last grid tick
        xl = x_left;
        yb = y_bottom;
        col_off = $signed(64'(pt.col_index) * 64'(step));
        row_off = $signed(64'(pt.row_index) * 64'(step));
        c_re = clip_q(xl + col_off);
        c_im = clip_q(yb + row_off);
        re = c_re;
        im = c_im;
        k = 0;
        escaped = 1'b0;
        while (k < max_iters && !escaped)
        begin
            rr = re * re;
            ii = im * im;
            ri = re * im;
            re = clip_q(((rr - ii) >>> FRAC_BITS) + c_re);
            im = clip_q((ri >>> (FRAC_BITS - 1)) + c_im);
            // exact Q8.56 magnitude, strict compare against radius 2
            mag = re * re + im * im;
            k++;
            if (mag > ESCAPE_SQ)
                escaped = 1'b1;
        end
        r.in_set = !escaped;
        r.iter_count = k[ITER_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            x_left = X_LEFT_RST;
            y_bottom = Y_BOTTOM_RST;
            step = STEP_RST;
            max_iters = MAX_ITER_RST;
            predicted_escapes.delete();
            mismatches = 0;
            in_flight = 0;
        end
        else
        begin
            // register write transfer
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_X_LEFT:    x_left = pwdata;
                    REG_Y_BOTTOM:  y_bottom = pwdata;
                    REG_STEP:      step = pwdata[STEP_W-1:0];
                    REG_MAX_ITERS: max_iters = pwdata[ITER_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest prediction
            if (pop && !empty)
            begin
                if (predicted_escapes.size() == 0)
                begin
                    $error("result transfer with no point pending: in_set %0d iter_count %0d",
                           result.in_set, result.iter_count);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = predicted_escapes.pop_front();
                    if (result.in_set !== want.in_set)
                    begin
                        $error("in_set: expected %0d, got %0d", want.in_set, result.in_set);
                        mismatches = mismatches + 1;
                    end
                    if (result.iter_count !== want.iter_count)
                    begin
                        $error("iter_count: expected %0d, got %0d",
                               want.iter_count, result.iter_count);
                        mismatches = mismatches + 1;
                    end
                end
            end

            // point transfer
            if (push && !full)
                predicted_escapes.push_back(escape_time(item));

            in_flight = predicted_escapes.size();
        end
    end

endmodule

### dv/mandelbrot_grid_point_test_top_test.sv
// ----------------------------------------------------------------------------
// mandelbrot_grid_point_test_top_test
// Drives grid points and view settings into the escape-time tester and gives
// the verdict. A directed set covers the corners of the index range, the
// escape boundary, a zero limit, saturating coordinates and the longest limit;
// random phases follow with and without idling on either queue side.
// ----------------------------------------------------------------------------
module mandelbrot_grid_point_test_top_test;
    import mbt_pkg::*;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push    = 1'b0;
    logic              full;
    in_item_t          item    = '0;
    logic              empty;
    logic              pop     = 1'b0;
    out_item_t         result;

    // idling odds in percent, per side
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int mismatches;
    int in_flight;

    mandelbrot_grid_point_test_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    escape_time_checker escape_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // result side, stalls at random
    always @(posedge clk)
        pop <= rst_n && ($urandom_range(0, 99) >= stall_pct);

    // run limit
    initial
    begin
        #60_000_000;
        $display("** mandelbrot_grid_point_test_top: FAILED **");
        $finish;
    end

    // one point transfer, with a random gap before it
    task automatic send_point(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        in_item_t pt;
        pt.col_index = col;
        pt.row_index = row;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        push <= 1'b1;
        item <= pt;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    // register write: setup then access
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // new view settings, only once the block has gone idle
    task automatic configure(input logic [31:0] xl, input logic [31:0] yb,
                             input logic [31:0] st, input logic [31:0] lim);
        drain();
        write_reg(REG_X_LEFT, xl);
        write_reg(REG_Y_BOTTOM, yb);
        write_reg(REG_STEP, st);
        write_reg(REG_MAX_ITERS, lim);
    endtask

    // mostly points inside a 3.0 by 2.5 window at the view origin, some anywhere
    task automatic run_random(input int unsigned count, input int unsigned st);
        int unsigned col_win;
        int unsigned row_win;
        col_win = 805306368 / st;
        row_win = 671088640 / st;
        if (col_win > GRID_MAX - 1)
            col_win = GRID_MAX - 1;
        if (row_win > GRID_MAX - 1)
            row_win = GRID_MAX - 1;
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 8)
                send_point(IDX_W'($urandom_range(0, col_win)),
                           IDX_W'($urandom_range(0, row_win)));
            else
                send_point(IDX_W'($urandom), IDX_W'($urandom));
        end
    endtask

    initial
    begin
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rs;
        logic [31:0] rm;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: start outside radius, corners, bit patterns, inner points
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'd20, 10'd10);
        send_point(10'd10, 10'd10);
        send_point(10'd5, 10'd10);
        send_point(10'd22, 10'd13);
        send_point(10'd27, 10'd10);
        send_point(10'd18, 10'd17);
        send_point(10'd682, 10'd341);
        send_point(10'd341, 10'd682);
        send_point(10'd512, 10'd1);
        send_point(10'd1, 10'd512);

        // c = -2 exactly: |z|^2 sits at 4 and must not count as escape
        configure(32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 32'd16);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);

        // zero iteration limit, extreme origins, upper bits of step and limit dropped
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd512, 10'd1);

        // coordinates saturate, single iteration
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd1023);

        // longest iteration limit, one point that never escapes
        configure(32'h0000_0000, 32'h0000_0000, 32'h0400_0000, 32'h0000_FFFF);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd3, 10'd1);

        // random views: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            rx = 32'hE000_0000 + $urandom_range(0, 32'h0400_0000);
            ry = 32'hEC00_0000 + $urandom_range(0, 32'h0200_0000);
            rs = $urandom_range(400000, 1000000);
            rm = $urandom_range(8, 200);
            configure(rx, ry, rs, rm);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            run_random(190, rs);
        end

        drain();
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("** mandelbrot_grid_point_test_top: PASSED **");
        else
            $display("** mandelbrot_grid_point_test_top: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_cfg.sv
hw/rtl/mbt_front.sv
hw/rtl/mbt_back.sv
hw/rtl/mandelbrot_grid_point_test_top.sv
dv/escape_time_checker.sv
dv/mandelbrot_grid_point_test_top_test.sv
